// ===== design/idq_pkg.sv =====
// Shared types and constants for the indexed double-ended queue.
package idq_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 8;
    localparam int CMD_W          = 4;
    localparam int STATUS_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT    = 4'd0,
        CMD_PUSH_BACK     = 4'd1,
        CMD_POP_FRONT     = 4'd2,
        CMD_POP_BACK      = 4'd3,
        CMD_GET           = 4'd4,
        CMD_FIND          = 4'd5,
        CMD_INSERT_AFTER  = 4'd6,
        CMD_INSERT_BEFORE = 4'd7,
        CMD_ERASE         = 4'd8,
        CMD_CLEAR         = 4'd9
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SH_NONE   = 2'd0,
        SH_INSERT = 2'd1,
        SH_ERASE  = 2'd2
    } shift_op_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        shift_op_t op;
        logic      scan_find;
    } cell_ctl_t;

endpackage

// ===== design/indexed_double_ended_queue.sv =====
// Top level of the indexed double-ended queue: command decode, chain of cells, result register.
//
// Usage: requests arrive on the s_ stream (s_tuser carries the command, s_tdata the value
// and position); one result per request leaves on the m_ stream (status, read value,
// found index and the size after the command).
// Push, pop front, insert, erase, clear, unused codes and every request that fails its
// checks need no scan: the result is registered at the accepting edge, so
// back-to-back requests run at one per cycle while m_tready stays high.
// Get, find and pop back that pass their checks send a scan token down the chain of DEPTH
// cells, one cell per cycle; their result is registered once the token leaves the last
// cell, and no request is taken meanwhile.
// Inserts and erases shift all cells in parallel.
// Reset empties the queue (size zero); element contents are not cleared and no sweep runs.
// A stalled receiver holds the result in the output register; a new request is taken
// only when that register is empty or being emptied in the same cycle.
module indexed_double_ended_queue #(
    parameter int DEPTH      = idq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int IN_W      = ((DATA_WIDTH + CW + 7) / 8) * 8,
    localparam int OUT_W     = ((idq_pkg::STATUS_W + DATA_WIDTH + 2 * CW + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,   // value, position
    input  logic [idq_pkg::CMD_W-1:0] s_tuser,   // command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_W-1:0]          m_tdata    // status, read_value, found_index, count
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    idq_pkg::status_t      out_status_reg, out_status_next;
    logic [DATA_WIDTH-1:0] out_rd_reg, out_rd_next;
    logic [CW-1:0]         out_fidx_reg, out_fidx_next;
    logic [CW-1:0]         out_count_reg, out_count_next;
    logic                  start_reg, start_next;
    logic                  scan_find_reg, scan_find_next;
    logic                  scan_pop_reg, scan_pop_next;
    logic [CW-1:0]         scan_pos_reg, scan_pos_next;
    logic [DATA_WIDTH-1:0] scan_key_reg, scan_key_next;

    logic                  accept;
    logic                  done_now;
    idq_pkg::cmd_t         cmd;
    logic [DATA_WIDTH-1:0] in_value;
    logic [CW-1:0]         in_pos;
    idq_pkg::status_t      st_now;
    logic [DATA_WIDTH-1:0] rd_now;
    logic [CW-1:0]         fidx_now;
    idq_pkg::cell_ctl_t    ctl;
    logic [CW-1:0]         shift_at;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  tok_valid [DEPTH+1];
    logic                  tok_hit   [DEPTH+1];
    logic [CW-1:0]         tok_idx   [DEPTH+1];
    logic [DATA_WIDTH-1:0] tok_data  [DEPTH+1];

    assign cmd      = idq_pkg::cmd_t'(s_tuser);
    assign in_value = s_tdata[DATA_WIDTH-1:0];
    assign in_pos   = s_tdata[DATA_WIDTH+CW-1:DATA_WIDTH];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Decode the request, drive the cell shift and complete the scan
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_fidx_next   = out_fidx_reg;
        out_count_next  = out_count_reg;
        start_next      = 1'b0;
        scan_find_next  = scan_find_reg;
        scan_pop_next   = scan_pop_reg;
        scan_pos_next   = scan_pos_reg;
        scan_key_next   = scan_key_reg;
        ctl.op          = idq_pkg::SH_NONE;
        ctl.scan_find   = scan_find_reg;
        shift_at        = '0;
        done_now        = 1'b1;
        st_now          = idq_pkg::ST_OK;
        rd_now          = '0;
        fidx_now        = '0;

        if (accept)
        begin
            unique case (cmd) inside
                idq_pkg::CMD_PUSH_FRONT, idq_pkg::CMD_PUSH_BACK:
                begin
                    if (count_reg == FULL_COUNT)
                        st_now = idq_pkg::ST_FULL;
                    else
                    begin
                        ctl.op     = idq_pkg::SH_INSERT;
                        shift_at   = (cmd == idq_pkg::CMD_PUSH_FRONT) ? '0 : count_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                idq_pkg::CMD_POP_FRONT:
                begin
                    if (count_reg == '0)
                        st_now = idq_pkg::ST_EMPTY;
                    else
                    begin
                        rd_now     = cell_data[0];
                        ctl.op     = idq_pkg::SH_ERASE;
                        shift_at   = '0;
                        count_next = count_reg - CW'(1);
                    end
                end
                idq_pkg::CMD_POP_BACK:
                begin
                    if (count_reg == '0)
                        st_now = idq_pkg::ST_EMPTY;
                    else
                    begin
                        done_now       = 1'b0;
                        start_next     = 1'b1;
                        scan_find_next = 1'b0;
                        scan_pop_next  = 1'b1;
                        scan_pos_next  = count_reg - CW'(1);
                        state_next     = ST_SCAN;
                    end
                end
                idq_pkg::CMD_GET:
                begin
                    if (count_reg == '0)
                        st_now = idq_pkg::ST_EMPTY;
                    else if (in_pos >= count_reg)
                        st_now = idq_pkg::ST_BAD_INDEX;
                    else
                    begin
                        done_now       = 1'b0;
                        start_next     = 1'b1;
                        scan_find_next = 1'b0;
                        scan_pop_next  = 1'b0;
                        scan_pos_next  = in_pos;
                        state_next     = ST_SCAN;
                    end
                end
                idq_pkg::CMD_FIND:
                begin
                    if (count_reg == '0)
                        st_now = idq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        done_now       = 1'b0;
                        start_next     = 1'b1;
                        scan_find_next = 1'b1;
                        scan_pop_next  = 1'b0;
                        scan_key_next  = in_value;
                        state_next     = ST_SCAN;
                    end
                end
                idq_pkg::CMD_INSERT_AFTER, idq_pkg::CMD_INSERT_BEFORE:
                begin
                    if (count_reg == FULL_COUNT)
                        st_now = idq_pkg::ST_FULL;
                    else if (count_reg == '0)
                    begin
                        ctl.op     = idq_pkg::SH_INSERT;
                        shift_at   = '0;
                        count_next = count_reg + CW'(1);
                    end
                    else if (in_pos >= count_reg)
                        st_now = idq_pkg::ST_BAD_INDEX;
                    else
                    begin
                        ctl.op     = idq_pkg::SH_INSERT;
                        shift_at   = (cmd == idq_pkg::CMD_INSERT_AFTER) ?
                                     in_pos + CW'(1) : in_pos;
                        count_next = count_reg + CW'(1);
                    end
                end
                idq_pkg::CMD_ERASE:
                begin
                    if (count_reg == '0)
                        st_now = idq_pkg::ST_EMPTY;
                    else if (in_pos >= count_reg)
                        st_now = idq_pkg::ST_BAD_INDEX;
                    else
                    begin
                        ctl.op     = idq_pkg::SH_ERASE;
                        shift_at   = in_pos;
                        count_next = count_reg - CW'(1);
                    end
                end
                idq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    st_now = idq_pkg::ST_OK;
                end
            endcase

            if (done_now)
            begin
                out_valid_next  = 1'b1;
                out_status_next = st_now;
                out_rd_next     = rd_now;
                out_fidx_next   = fidx_now;
                out_count_next  = count_next;
            end
        end

        // Token left the last cell: report the scan
        if (state_reg == ST_SCAN && tok_valid[DEPTH])
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            if (scan_find_reg)
            begin
                out_rd_next = '0;
                if (tok_hit[DEPTH])
                begin
                    out_status_next = idq_pkg::ST_OK;
                    out_fidx_next   = tok_idx[DEPTH];
                end
                else
                begin
                    out_status_next = idq_pkg::ST_NOT_FOUND;
                    out_fidx_next   = count_reg;
                end
            end
            else
            begin
                out_status_next = idq_pkg::ST_OK;
                out_rd_next     = tok_data[DEPTH];
                out_fidx_next   = '0;
            end
            if (scan_pop_reg)
                count_next = count_reg - CW'(1);
            out_count_next = count_next;
        end
    end

    // Hold state, size, scan setup and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            start_reg      <= 1'b0;
            out_status_reg <= idq_pkg::ST_OK;
            out_rd_reg     <= '0;
            out_fidx_reg   <= '0;
            out_count_reg  <= '0;
            scan_find_reg  <= 1'b0;
            scan_pop_reg   <= 1'b0;
            scan_pos_reg   <= '0;
            scan_key_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            start_reg      <= start_next;
            out_status_reg <= out_status_next;
            out_rd_reg     <= out_rd_next;
            out_fidx_reg   <= out_fidx_next;
            out_count_reg  <= out_count_next;
            scan_find_reg  <= scan_find_next;
            scan_pop_reg   <= scan_pop_next;
            scan_pos_reg   <= scan_pos_next;
            scan_key_reg   <= scan_key_next;
        end
    end

    // Inject the scan token at the front cell
    assign tok_valid[0] = start_reg;
    assign tok_hit[0]   = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_data[0]  = '0;

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        idq_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .at            (shift_at),
            .ins_value     (in_value),
            .left_data     (left_d),
            .right_data    (right_d),
            .key           (scan_key_reg),
            .pos           (scan_pos_reg),
            .count         (count_reg),
            .tok_in_valid  (tok_valid[i]),
            .tok_in_hit    (tok_hit[i]),
            .tok_in_idx    (tok_idx[i]),
            .tok_in_data   (tok_data[i]),
            .data          (cell_data[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out_hit   (tok_hit[i+1]),
            .tok_out_idx   (tok_idx[i+1]),
            .tok_out_data  (tok_data[i+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_count_reg, out_fidx_reg, out_rd_reg, out_status_reg});

endmodule

// ===== design/idq_cell.sv =====
// One storage cell of the queue chain: holds an element and passes the scan token on.
module idq_cell #(
    parameter int DEPTH      = idq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  idq_pkg::cell_ctl_t    ctl,
    input  logic [CW-1:0]         at,
    input  logic [DATA_WIDTH-1:0] ins_value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [CW-1:0]         pos,
    input  logic [CW-1:0]         count,
    input  logic                  tok_in_valid,
    input  logic                  tok_in_hit,
    input  logic [CW-1:0]         tok_in_idx,
    input  logic [DATA_WIDTH-1:0] tok_in_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  tok_out_valid,
    output logic                  tok_out_hit,
    output logic [CW-1:0]         tok_out_idx,
    output logic [DATA_WIDTH-1:0] tok_out_data
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  tok_valid_reg, tok_valid_next;
    logic                  tok_hit_reg, tok_hit_next;
    logic [CW-1:0]         tok_idx_reg, tok_idx_next;
    logic [DATA_WIDTH-1:0] tok_data_reg, tok_data_next;
    logic                  hit;

    // Shift toward the back on insert, toward the front on erase
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            idq_pkg::SH_INSERT:
            begin
                if (MY_IDX > at)
                    data_next = left_data;
                else if (MY_IDX == at)
                    data_next = ins_value;
            end
            idq_pkg::SH_ERASE:
            begin
                if (MY_IDX >= at)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Claim the token on the first match or the requested index
    assign hit = tok_in_valid && !tok_in_hit && (MY_IDX < count) &&
                 (ctl.scan_find ? (data_reg == key) : (MY_IDX == pos));

    always_comb
    begin
        tok_valid_next = tok_in_valid;
        tok_hit_next   = tok_in_hit;
        tok_idx_next   = tok_in_idx;
        tok_data_next  = tok_in_data;
        if (hit)
        begin
            tok_hit_next  = 1'b1;
            tok_idx_next  = MY_IDX;
            tok_data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        tok_hit_reg  <= tok_hit_next;
        tok_idx_reg  <= tok_idx_next;
        tok_data_reg <= tok_data_next;
    end

    assign data          = data_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_hit   = tok_hit_reg;
    assign tok_out_idx   = tok_idx_reg;
    assign tok_out_data  = tok_data_reg;

endmodule
